// ----- hw/rtl/pbme_pkg.sv -----
// ----------------------------------------------------------------------------
// pbme_pkg: shared types and constants
// Widths, status codes and limits for the progressive block mean/error core.
// ----------------------------------------------------------------------------
package pbme_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int CNT_W      = 11;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NEG_MEAN = 2'd1;
    localparam t_status ST_ZERO_ROOT = 2'd2;
    localparam t_status ST_OVERFLOW = 2'd3;

endpackage

// ----- hw/rtl/pbme_if.sv -----
// ----------------------------------------------------------------------------
// pbme_in_if / pbme_out_if: valid/ready channels
// One beat carries one block input or one result.
// ----------------------------------------------------------------------------
interface pbme_in_if;
    import pbme_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [31:0] block_mean;
    logic        [31:0] block_mean_sq;
    logic               last_block;
    modport source (output valid, block_mean, block_mean_sq, last_block, input ready);
    modport sink   (input valid, block_mean, block_mean_sq, last_block, output ready);
endinterface

interface pbme_out_if;
    import pbme_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [31:0] running_mean;
    logic        [31:0] running_error;
    logic        [23:0] root_value;
    logic        [31:0] root_error;
    logic [CNT_W-1:0]   blocks_seen;
    logic               final_flag;
    t_status            status;
    modport source (output valid, running_mean, running_error, root_value, root_error,
                    blocks_seen, final_flag, status, input ready);
    modport sink   (input valid, running_mean, running_error, root_value, root_error,
                    blocks_seen, final_flag, status, output ready);
endinterface

// ----- hw/rtl/progressive_block_mean_error_core.sv -----
// ----------------------------------------------------------------------------
// progressive_block_mean_error_core: blocking-method mean and error
// Running sums of block averages; one shared compare/subtract unit runs all
// divisions and square roots under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one beat per block (block_mean, block_mean_sq, last_block).
//   o_out : at most one result beat per input beat.
//   i_cfg_we / i_cfg_wdata : output_mode, written while idle.
// Mode 0 emits mean and error for every block; mode 1 accumulates and emits
// only on the last block, adding the root and its propagated error.
// Timing: i_in.ready is high only while idle. Each division and each square
// root is first loaded into the shared compare/subtract unit and then steps
// there; the multiply and the output load are states of their own. A beat
// that makes a result raises o_out.valid as the block returns to idle, and
// i_in.ready returns in that same cycle, so the block takes no new beat
// until the result of the last one is in the output register. A mode 1
// beat that is not the last block leaves the block idle.
// The result is held in the output register until o_out.ready; while the
// receiver stalls, the block waits before loading the next result.
// Reset clears the sums, the count, the mode and the output valid.
// ----------------------------------------------------------------------------
module progressive_block_mean_error_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    pbme_in_if.sink     i_in,
    pbme_out_if.source  o_out
);
    import pbme_pkg::*;

    localparam int DIV_STEPS  = 43;
    localparam int SQRT_STEPS = 25;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MEAN = 9'b000000010,
        S_MSQ  = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_VAR  = 9'b000010000,
        S_ERR  = 9'b000100000,
        S_ROOT = 9'b001000000,
        S_RERR = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic              r_mode, n_mode;
    logic signed [42:0] r_sum, n_sum;
    logic [41:0]       r_sqs, n_sqs;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_last, n_last;
    logic signed [31:0] r_mean, n_mean;
    logic [31:0]       r_msq, n_msq;
    logic [63:0]       r_prod, n_prod;
    logic [31:0]       r_vq, n_vq;
    logic [23:0]       r_err, n_err;
    logic [23:0]       r_root, n_root;
    logic [31:0]       r_rerr, n_rerr;
    t_status           r_status, n_status;

    logic [49:0]       r_acc, n_acc;
    logic [25:0]       r_rem, n_rem;
    logic [42:0]       r_q, n_q;
    logic [24:0]       r_den, n_den;
    logic [5:0]        r_cnt, n_cnt;
    logic              r_sqrt, n_sqrt;
    logic              r_run, n_run;

    logic              r_ov, n_ov;
    logic signed [31:0] r_o_mean, n_o_mean;
    logic [31:0]       r_o_err, n_o_err;
    logic [23:0]       r_o_root, n_o_root;
    logic [31:0]       r_o_rerr, n_o_rerr;
    logic [CNT_W-1:0]  r_o_seen, n_o_seen;
    logic              r_o_fin, n_o_fin;
    t_status           r_o_status, n_o_status;

    logic [27:0] u_sh, u_trial, u_diff;
    logic        u_ge, u_done;
    logic [42:0] u_qn;
    logic [42:0] sum_mag;
    logic [31:0] mean_mag;
    logic [49:0] var_raw;
    logic [31:0] var_clamp;
    logic        in_acc;

    always_comb begin
        if (r_sqrt) begin
            u_sh    = {r_rem, r_acc[49:48]};
            u_trial = {1'b0, r_q[24:0], 2'b01};
        end else begin
            u_sh    = {1'b0, r_rem, r_acc[49]};
            u_trial = {3'b000, r_den};
        end
        u_ge   = (u_sh >= u_trial);
        u_diff = u_sh - u_trial;
        u_qn   = {r_q[41:0], u_ge};
        u_done = r_run && (r_cnt == 6'd1);
    end

    assign sum_mag   = r_sum[42] ? 43'(-r_sum) : 43'(r_sum);
    assign mean_mag  = r_mean[31] ? 32'(-r_mean) : 32'(r_mean);
    assign var_raw   = {18'b0, r_msq} - {2'b0, r_prod[63:16]};
    assign var_clamp = var_raw[49] ? 32'd0 : var_raw[31:0];
    assign in_acc    = i_in.valid && i_in.ready;

    always_comb begin
        n_state = r_state;  n_mode = r_mode;  n_sum = r_sum;  n_sqs = r_sqs;
        n_count = r_count;  n_last = r_last;  n_mean = r_mean; n_msq = r_msq;
        n_prod = r_prod;    n_vq = r_vq;      n_err = r_err;   n_root = r_root;
        n_rerr = r_rerr;    n_status = r_status;
        n_acc = r_acc;      n_rem = r_rem;    n_q = r_q;       n_den = r_den;
        n_cnt = r_cnt;      n_sqrt = r_sqrt;  n_run = r_run;
        n_ov = r_ov;        n_o_mean = r_o_mean; n_o_err = r_o_err;
        n_o_root = r_o_root; n_o_rerr = r_o_rerr; n_o_seen = r_o_seen;
        n_o_fin = r_o_fin;  n_o_status = r_o_status;

        if (i_cfg_we) begin
            n_mode = i_cfg_wdata;
        end
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        // advance the shared unit
        if (r_run) begin
            n_acc = r_sqrt ? {r_acc[47:0], 2'b00} : {r_acc[48:0], 1'b0};
            n_rem = u_ge ? u_diff[25:0] : u_sh[25:0];
            n_q   = u_qn;
            n_cnt = r_cnt - 6'd1;
            if (u_done) begin
                n_run = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last   = i_in.last_block;
                    n_root   = '0;
                    n_rerr   = '0;
                    n_status = ST_OK;
                    if (r_count >= CNT_W'(MAX_BLOCKS)) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        n_sum   = r_sum + 43'(i_in.block_mean);
                        n_sqs   = r_sqs + {10'b0, i_in.block_mean_sq};
                        n_count = r_count + CNT_W'(1);
                    end
                    if (!(r_mode && !i_in.last_block)) begin
                        n_state = S_MEAN;
                    end
                end
            end
            S_MEAN: begin
                if (!r_run) begin
                    n_acc = {sum_mag, 7'b0};  n_den = 25'(r_count);
                    n_sqrt = 1'b0; n_q = '0; n_rem = '0;
                    n_cnt = 6'(DIV_STEPS); n_run = 1'b1;
                end else if (u_done) begin
                    n_mean  = r_sum[42] ? 32'(-u_qn[31:0]) : u_qn[31:0];
                    n_state = S_MSQ;
                end
            end
            S_MSQ: begin
                if (!r_run) begin
                    n_acc = {1'b0, r_sqs, 7'b0};  n_den = 25'(r_count);
                    n_sqrt = 1'b0; n_q = '0; n_rem = '0;
                    n_cnt = 6'(DIV_STEPS); n_run = 1'b1;
                end else if (u_done) begin
                    n_msq = u_qn[31:0];
                    if (r_count == CNT_W'(1)) begin
                        n_err = '0;
                        if (r_mode && r_status == ST_OK) begin
                            n_state = r_mean[31] ? S_OUT : S_ROOT;
                            if (r_mean[31]) n_status = ST_NEG_MEAN;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod  = mean_mag * mean_mag;
                n_state = S_VAR;
            end
            S_VAR: begin
                if (!r_run) begin
                    n_acc = {11'b0, var_clamp, 7'b0};
                    n_den = 25'(r_count - CNT_W'(1));
                    n_sqrt = 1'b0; n_q = '0; n_rem = '0;
                    n_cnt = 6'(DIV_STEPS); n_run = 1'b1;
                end else if (u_done) begin
                    n_vq    = u_qn[31:0];
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                if (!r_run) begin
                    n_acc = {2'b0, r_vq, 16'b0};
                    n_sqrt = 1'b1; n_q = '0; n_rem = '0;
                    n_cnt = 6'(SQRT_STEPS); n_run = 1'b1;
                end else if (u_done) begin
                    n_err = u_qn[23:0];
                    if (r_mode && r_status == ST_OK) begin
                        n_state = r_mean[31] ? S_OUT : S_ROOT;
                        if (r_mean[31]) n_status = ST_NEG_MEAN;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_ROOT: begin
                if (!r_run) begin
                    n_acc = {2'b0, r_mean, 16'b0};
                    n_sqrt = 1'b1; n_q = '0; n_rem = '0;
                    n_cnt = 6'(SQRT_STEPS); n_run = 1'b1;
                end else if (u_done) begin
                    if (u_qn[23:0] == 24'd0) begin
                        n_status = ST_ZERO_ROOT;
                        n_state  = S_OUT;
                    end else begin
                        n_root  = u_qn[23:0];
                        n_state = S_RERR;
                    end
                end
            end
            S_RERR: begin
                if (!r_run) begin
                    n_acc = {3'b0, r_err, 16'b0, 7'b0};  n_den = {r_root, 1'b0};
                    n_sqrt = 1'b0; n_q = '0; n_rem = '0;
                    n_cnt = 6'(DIV_STEPS); n_run = 1'b1;
                end else if (u_done) begin
                    n_rerr  = (|u_qn[42:32]) ? 32'hFFFF_FFFF : u_qn[31:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || o_out.ready) begin
                    n_ov       = 1'b1;
                    n_o_mean   = r_mean;
                    n_o_err    = {8'b0, r_err};
                    n_o_root   = r_root;
                    n_o_rerr   = r_rerr;
                    n_o_seen   = r_count;
                    n_o_fin    = r_last;
                    n_o_status = r_status;
                    if (r_last) begin
                        n_sum = '0; n_sqs = '0; n_count = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= 1'b0; r_sum <= '0; r_sqs <= '0;
            r_count <= '0;     r_run <= 1'b0;  r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_mode <= n_mode; r_sum <= n_sum; r_sqs <= n_sqs;
            r_count <= n_count; r_run <= n_run;   r_ov <= n_ov;
        end
        r_last <= n_last;   r_mean <= n_mean; r_msq <= n_msq;   r_prod <= n_prod;
        r_vq <= n_vq;       r_err <= n_err;   r_root <= n_root; r_rerr <= n_rerr;
        r_status <= n_status;
        r_acc <= n_acc; r_rem <= n_rem; r_q <= n_q; r_den <= n_den;
        r_cnt <= n_cnt; r_sqrt <= n_sqrt;
        r_o_mean <= n_o_mean; r_o_err <= n_o_err; r_o_root <= n_o_root;
        r_o_rerr <= n_o_rerr; r_o_seen <= n_o_seen; r_o_fin <= n_o_fin;
        r_o_status <= n_o_status;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_ov;
    assign o_out.running_mean  = r_o_mean;
    assign o_out.running_error = r_o_err;
    assign o_out.root_value    = r_o_root;
    assign o_out.root_error    = r_o_rerr;
    assign o_out.blocks_seen   = r_o_seen;
    assign o_out.final_flag    = r_o_fin;
    assign o_out.status        = r_o_status;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count above limit");

    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT || r_state == S_MUL) |-> !r_run)
        else $error("shared unit running outside an arithmetic step");

    a_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_status != ST_OK) |-> (r_o_root == 24'd0 && r_o_rerr == 32'd0))
        else $error("root fields set on a flagged result");

endmodule

// ----- tb/sv/pbme_test_if.sv -----
// ----------------------------------------------------------------------------
// pbme test channel helpers
// Holds no logic of its own; the channel interfaces come from the RTL.
// ----------------------------------------------------------------------------
package pbme_test_pkg;
    import pbme_pkg::*;

    typedef struct packed {
        logic signed [31:0] mean;
        logic        [31:0] mean_sq;
        logic               last;
    } t_block_beat;

    typedef struct packed {
        logic signed [31:0] running_mean;
        logic        [31:0] running_error;
        logic        [23:0] root_value;
        logic        [31:0] root_error;
        logic [CNT_W-1:0]   blocks_seen;
        logic               final_flag;
        t_status            status;
    } t_stat_result;
endpackage

// ----- tb/sv/progressive_block_mean_error_core_test.sv -----
// ----------------------------------------------------------------------------
// progressive_block_mean_error_core_test: self-checking bench
// Drives block averages through bursty valid/ready traffic in both output
// modes, predicts every result with a running-sum model and compares beats.
// ----------------------------------------------------------------------------
module progressive_block_mean_error_core_test;
    import pbme_pkg::*;
    import pbme_test_pkg::*;

    localparam int SETTLE = 400;
    localparam int N_ROWS = 14;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    pbme_in_if  blk_ch();
    pbme_out_if res_ch();

    progressive_block_mean_error_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (blk_ch.sink),
        .o_out      (res_ch.source)
    );

    logic              mode_q;
    logic signed [63:0] sum_mean_q;
    logic        [63:0] sum_sq_q;
    int unsigned        count_q;

    t_stat_result pending_q[$];
    t_stat_result last_got;
    int  errors = 0;
    int  checked = 0;
    int  fed = 0;
    bit  stall_on = 1'b1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Advance the running sums by one block; queue the result it causes.
    task automatic predict_block(input t_block_beat b);
        logic               ovf;
        logic signed [63:0] n, avg, msq, m2, var_v, mag;
        logic        [63:0] err, root, rerr;
        t_stat_result       r;
        ovf = 1'b0;
        err = 0;
        root = 0;
        rerr = 0;
        if (count_q >= MAX_BLOCKS) begin
            ovf = 1'b1;
        end else begin
            sum_mean_q += 64'(b.mean);
            sum_sq_q   += {32'd0, b.mean_sq};
            count_q++;
        end
        if (mode_q && !b.last) return;
        n = count_q;
        if (n > 0) begin
            avg = sum_mean_q / n;
            msq = $signed(sum_sq_q / n);
        end else begin
            avg = 0;
            msq = 0;
        end
        mag = avg < 0 ? -avg : avg;
        m2 = $signed((mag * mag) >> 16);
        if (n > 1) begin
            var_v = msq - m2;
            if (var_v < 0) var_v = 0;
            var_v = var_v / (n - 1);
            err = floor_sqrt(var_v << 16);
        end
        r.status = ovf ? ST_OVERFLOW : ST_OK;
        if (mode_q) begin
            if (r.status == ST_OK && avg < 0) r.status = ST_NEG_MEAN;
            if (r.status == ST_OK) begin
                root = floor_sqrt(avg << 16);
                if (root == 0) r.status = ST_ZERO_ROOT;
            end
            if (r.status == ST_OK) begin
                rerr = (err << 16) / (2 * root);
                if (rerr > 64'hFFFF_FFFF) rerr = 64'hFFFF_FFFF;
            end else begin
                root = 0;
                rerr = 0;
            end
        end
        r.running_mean  = avg[31:0];
        r.running_error = err[31:0];
        r.root_value    = root[23:0];
        r.root_error    = rerr[31:0];
        r.blocks_seen   = count_q[CNT_W-1:0];
        r.final_flag    = b.last;
        pending_q = {pending_q, r};
        if (b.last) begin
            sum_mean_q = 0;
            sum_sq_q = 0;
            count_q = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && blk_ch.valid && blk_ch.ready) begin
            predict_block({blk_ch.block_mean, blk_ch.block_mean_sq, blk_ch.last_block});
            fed++;
        end
    end

    always @(posedge i_clk) begin
        t_stat_result got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.running_mean, res_ch.running_error, res_ch.root_value,
                   res_ch.root_error, res_ch.blocks_seen, res_ch.final_flag,
                   res_ch.status};
            last_got = got;
            checked++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp mean %h err %h root %h rerr %h n %0d f %b st %0d",
                            want.running_mean, want.running_error, want.root_value,
                            want.root_error, want.blocks_seen, want.final_flag,
                            want.status);
                        $display("          got mean %h err %h root %h rerr %h n %0d f %b st %0d",
                            got.running_mean, got.running_error, got.root_value,
                            got.root_error, got.blocks_seen, got.final_flag,
                            got.status);
                    end
                end
            end
        end
    end

    // Receiver stalls on its own pattern.
    initial begin
        int phase;
        res_ch.ready = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (!stall_on || phase[9:7] == 3'd5)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(0, 3) != 0) ^ phase[4];
        end
    end

    // Hold valid after the beat; a following pause or drain drops it.
    task automatic send_block(input logic signed [31:0] m, input logic [31:0] sq,
                              input logic lb);
        blk_ch.valid <= 1'b1;
        blk_ch.block_mean <= m;
        blk_ch.block_mean_sq <= sq;
        blk_ch.last_block <= lb;
        do @(posedge i_clk); while (!blk_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            blk_ch.valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic gap();
        pause($urandom_range(0, 4));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        blk_ch.valid <= 1'b0;
        while (pending_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mode_q = m;
    endtask

    function automatic logic signed [31:0] rand_mean(input bit positive);
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            default: v = $urandom_range(0, 32'h0400_0000);
        endcase
        if (positive && v < 0) v = -v;
        return v;
    endfunction

    // Directed rows: mean, mean_sq, last, mode; expected mean and status where
    // chk is set, all other fields from the predictor.
    typedef struct {
        logic signed [31:0] m;
        logic [31:0]        sq;
        logic               lb;
        logic               mode;
        logic               chk;
        logic signed [31:0] exp_mean;
        t_status            exp_st;
    } t_row;

    t_row rows[N_ROWS] = '{
        '{32'sh0001_0000, 32'h0001_0000, 1'b1, 1'b0, 1'b1, 32'sh0001_0000, ST_OK},
        '{32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 32'sh7FFF_FFFF, ST_OK},
        '{32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 32'sh7FFF_FFFF, ST_OK},
        '{32'sh8000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 32'sh8000_0000, ST_OK},
        '{32'sh8000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 32'sh8000_0000, ST_OK},
        '{32'sh0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'sh0, ST_OK},
        '{32'sh0002_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'sh0, ST_OK},
        '{32'sh0004_0000, 32'h0010_0000, 1'b0, 1'b1, 1'b0, 32'sh0, ST_OK},
        '{32'sh0004_8000, 32'h0015_0000, 1'b1, 1'b1, 1'b0, 32'sh0, ST_OK},
        '{-32'sh0004_0000, 32'h0010_0000, 1'b1, 1'b1, 1'b1, -32'sh0004_0000, ST_NEG_MEAN},
        '{32'sh0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'sh0, ST_ZERO_ROOT},
        '{32'sh0000_0001, 32'h0000_0001, 1'b1, 1'b1, 1'b0, 32'sh0, ST_OK},
        '{32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'sh0, ST_OK},
        '{32'sh0001_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 32'sh0, ST_OK}
    };

    initial begin
        int done_rows, series;
        logic cur_mode;
        blk_ch.valid = 1'b0;
        blk_ch.block_mean = '0;
        blk_ch.block_mean_sq = '0;
        blk_ch.last_block = 1'b0;
        mode_q = 1'b0;
        sum_mean_q = 0;
        sum_sq_q = 0;
        count_q = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First row is the first beat after reset: mean 1.0, error 0.
        cur_mode = 1'b0;
        for (int i = 0; i < N_ROWS; i++) begin
            if (rows[i].mode != cur_mode) begin
                drain();
                set_mode(rows[i].mode);
                cur_mode = rows[i].mode;
            end
            send_block(rows[i].m, rows[i].sq, rows[i].lb);
            if (rows[i].chk) begin
                drain();
                if (last_got.running_mean !== rows[i].exp_mean ||
                    last_got.status !== rows[i].exp_st) begin
                    errors++;
                    if (errors <= 10)
                        $display("row %0d: exp mean %h st %0d | got mean %h st %0d", i,
                            rows[i].exp_mean, rows[i].exp_st, last_got.running_mean,
                            last_got.status);
                end
            end else begin
                gap();
            end
        end
        drain();

        // Overflow: fill past MAX_BLOCKS quietly in mode 1, report the dropped
        // blocks in mode 0, then close the series in mode 1.
        set_mode(1'b1);
        for (int i = 0; i < MAX_BLOCKS + 3; i++)
            send_block(rand_mean(1), $urandom, 1'b0);
        drain();
        set_mode(1'b0);
        stall_on = 1'b0;
        repeat (2) send_block(32'sh0000_0100, 32'h0000_0100, 1'b0);
        stall_on = 1'b1;
        drain();
        set_mode(1'b1);
        send_block(32'sh0003_0000, 32'h0009_0000, 1'b1);
        drain();

        // Random series: mostly well-formed blocks with sane mean squares.
        done_rows = 0;
        series = 0;
        while (done_rows < 750) begin
            int len;
            logic signed [31:0] m;
            logic [31:0] sq;
            logic [63:0] mm;
            if (series % 6 == 0) begin
                drain();
                set_mode(1'($urandom_range(0, 1)));
            end
            series++;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                m = rand_mean(mode_q && $urandom_range(0, 4) != 0);
                mm = (m < 0 ? -64'(m) : 64'(m));
                mm = (mm * mm) >> 16;
                if ($urandom_range(0, 4) == 0 || mm > 64'hFFFF_0000)
                    sq = $urandom;
                else
                    sq = mm[31:0] + $urandom_range(0, 32'h0004_0000);
                send_block(m, sq, k == len - 1);
                done_rows++;
                if ($urandom_range(0, 2) == 0) gap();
                if ($urandom_range(0, 9) == 0) pause($urandom_range(5, 40));
            end
        end
        drain();

        $display("Fed %0d block beats across both modes, including overflow runs.", fed);
        $display("Compared %0d result beats.", checked);
        if (errors == 0 && pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
